FILE: src/fhist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhist_pkg
// Types and codes shared by the fixed-range histogram core: item layouts,
// command codes, register indexes and the job handed from front to back.
// ----------------------------------------------------------------------------
package fhist_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [1:0] REG_X_MIN         = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH     = 2'd1;
  localparam logic [1:0] REG_INV_BIN_WIDTH = 2'd2;

  typedef struct packed {
    cmd_e               cmd;
    logic [2:0]         channel;
    logic signed [31:0] sample_value;
    logic               closes_set;
    logic [7:0]         bin_index;
  } in_item_t;

  typedef struct packed {
    logic               in_range;
    logic [31:0]        raw_count;
    logic [31:0]        density;
    logic signed [31:0] left_edge;
    logic [31:0]        set_total;
  } out_item_t;

  typedef struct packed {
    cmd_e               op;
    logic               hit;
    logic               closes;
    logic signed [31:0] left_edge;
  } job_t;

endpackage

FILE: src/fixed_range_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_range_histogram_core
// Multi-channel Q16.16 histogram: add, read with density, and clear.
// ----------------------------------------------------------------------------
// The front takes one item per cycle, unless full is high, into a two-stage
// classify pipeline and a two-entry job queue, so it keeps accepting while a
// result waits on the output, until the pipeline and queue fill. The back
// sets the sustained rate through its single counter store: an add is a
// memory read, then a write; a read is a memory read, a denominator multiply
// and a 32-step restoring divide, with no divide when the density is zero or
// saturated; an unused command is a memory read, then done; a clear sweeps
// the whole store. After reset the store is cleared with full held high;
// configuration writes are taken throughout.
module fixed_range_histogram_core #(
  parameter int CHANNELS = 8,
  parameter int BINS     = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  fhist_pkg::in_item_t   in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output fhist_pkg::out_item_t  out_item_o
);

  import fhist_pkg::*;

  localparam int DEPTH  = CHANNELS * BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int QW     = $bits(job_t) + ADDR_W;

  logic signed [31:0] x_min_q;
  logic [30:0]        bin_width_q;
  logic [31:0]        inv_bin_width_q;

  logic               f_push, q_full, q_empty, b_pop, init_busy, out_valid;
  job_t               f_job, q_job;
  logic [ADDR_W-1:0]  f_addr, q_addr;
  logic [QW-1:0]      q_rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [31:0]        mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q         <= '0;
      bin_width_q     <= 31'd65536;
      inv_bin_width_q <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_MIN:         x_min_q         <= cfg_wdata_i;
        REG_BIN_WIDTH:     bin_width_q     <= cfg_wdata_i[30:0];
        REG_INV_BIN_WIDTH: inv_bin_width_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  fhist_front #(
    .CHANNELS (CHANNELS),
    .BINS     (BINS),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .item_i          (in_item_i),
    .full_o          (full),
    .hold_i          (init_busy),
    .x_min_i         (x_min_q),
    .bin_width_i     (bin_width_q),
    .inv_bin_width_i (inv_bin_width_q),
    .job_push_o      (f_push),
    .job_o           (f_job),
    .job_addr_o      (f_addr),
    .job_full_i      (q_full)
  );

  fhist_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_job, f_addr}),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign q_job  = q_rdata[QW-1:ADDR_W];
  assign q_addr = q_rdata[ADDR_W-1:0];

  fhist_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fhist_back #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (q_job),
    .job_addr_i  (q_addr),
    .job_pop_o   (b_pop),
    .bin_width_i (bin_width_q),
    .init_busy_o (init_busy),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o),
    .pop_i       (pop)
  );

  assign empty = !out_valid;

endmodule

FILE: src/fhist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhist_ram
// Generic RAM: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module fhist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/fhist_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhist_queue
// Short register queue that decouples the classify front from the back.
// ----------------------------------------------------------------------------
module fhist_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/fhist_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhist_front
// Accept and classify items: offset, reciprocal multiply, range check, bin
// address and left edge, in a two-stage pipeline feeding the job queue.
// ----------------------------------------------------------------------------
module fhist_front #(
  parameter int CHANNELS = 8,
  parameter int BINS     = 256,
  parameter int ADDR_W   = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  fhist_pkg::in_item_t       item_i,
  output logic                      full_o,
  input  logic                      hold_i,
  input  logic signed [31:0]        x_min_i,
  input  logic [30:0]               bin_width_i,
  input  logic [31:0]               inv_bin_width_i,
  output logic                      job_push_o,
  output fhist_pkg::job_t           job_o,
  output logic [ADDR_W-1:0]         job_addr_o,
  input  logic                      job_full_i
);

  import fhist_pkg::*;

  localparam int BIN_W = $clog2(BINS);

  logic               s1_valid_q, s2_valid_q;
  in_item_t           s1_item_q, s2_item_q;
  logic signed [32:0] s1_diff_q;
  logic               s2_neg_q;
  logic [63:0]        s2_mul_q;
  logic [38:0]        s2_eprod_q;

  logic               accept, s1_adv, s2_adv;
  logic [31:0]        bin;
  logic               counted, ch_ok, bidx_ok;
  logic [31:0]        bin_sel;
  logic signed [39:0] edge_sum;
  logic signed [31:0] edge_sat;

  assign s2_adv = s2_valid_q && !job_full_i;
  assign s1_adv = s1_valid_q && (!s2_valid_q || s2_adv);
  assign full_o = hold_i || (s1_valid_q && !s1_adv);
  assign accept = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_i;
      s1_diff_q <= {item_i.sample_value[31], item_i.sample_value} - {x_min_i[31], x_min_i};
    end
    if (s1_adv) begin
      s2_item_q  <= s1_item_q;
      s2_neg_q   <= s1_diff_q[32];
      s2_mul_q   <= 64'(s1_diff_q[31:0]) * 64'(inv_bin_width_i);
      s2_eprod_q <= 39'(s1_item_q.bin_index) * 39'(bin_width_i);
    end
  end

  always_comb begin
    bin      = s2_mul_q[63:32];
    counted  = s2_neg_q ? (inv_bin_width_i == '0) : (bin < 32'(BINS));
    ch_ok    = 32'(s2_item_q.channel) < 32'(CHANNELS);
    bidx_ok  = 32'(s2_item_q.bin_index) < 32'(BINS);
    edge_sum = 40'(x_min_i) + $signed({1'b0, s2_eprod_q});
    edge_sat = (!edge_sum[39] && (|edge_sum[38:31])) ? 32'sh7FFFFFFF : edge_sum[31:0];

    job_o.op        = s2_item_q.cmd;
    job_o.closes    = s2_item_q.closes_set;
    job_o.hit       = 1'b0;
    job_o.left_edge = '0;
    bin_sel         = '0;
    case (s2_item_q.cmd)
      CMD_ADD: begin
        job_o.hit = counted && ch_ok;
        bin_sel   = s2_neg_q ? '0 : 32'(s2_mul_q[32 +: BIN_W]);
      end
      CMD_READ: begin
        job_o.hit       = ch_ok && bidx_ok;
        job_o.left_edge = edge_sat;
        bin_sel         = 32'(s2_item_q.bin_index);
      end
      default: begin
      end
    endcase
    job_addr_o = ADDR_W'(32'(s2_item_q.channel) * 32'(BINS) + bin_sel);
  end

  assign job_push_o = s2_adv;

endmodule

FILE: src/fhist_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhist_back
// Carry out jobs against the counter store: increment, read with density
// division, clear sweep, set count, and the output register.
// ----------------------------------------------------------------------------
module fhist_back #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  fhist_pkg::job_t           job_i,
  input  logic [ADDR_W-1:0]         job_addr_i,
  output logic                      job_pop_o,
  input  logic [30:0]               bin_width_i,
  output logic                      init_busy_o,
  output logic                      mem_we_o,
  output logic [ADDR_W-1:0]         mem_waddr_o,
  output logic [31:0]               mem_wdata_o,
  output logic [ADDR_W-1:0]         mem_raddr_o,
  input  logic [31:0]               mem_rdata_i,
  output logic                      out_valid_o,
  output fhist_pkg::out_item_t      out_item_o,
  input  logic                      pop_i
);

  import fhist_pkg::*;

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_EXEC, B_DEN, B_DIV, B_CLR, B_OUT
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFFFFFF) ? v : v + 32'd1;
  endfunction

  state_e            state_q, state_d;
  job_t              cur_q, cur_d;
  logic [ADDR_W-1:0] addr_q, addr_d, sweep_q, sweep_d;
  logic [31:0]       cnt_q, cnt_d, set_q, set_d, quo_q, quo_d;
  logic [62:0]       den_q, den_d;
  logic [63:0]       rem_q, rem_d;
  logic [4:0]        step_q, step_d;
  out_item_t         res_q, res_d, out_q, out_d, fin_res;
  logic              out_valid_q, out_valid_d;
  logic              fin, out_free, sweep_last, ge;
  logic [63:0]       rem_sh;
  logic [31:0]       quo_nxt;

  assign out_free   = !out_valid_q || pop_i;
  assign sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));
  assign rem_sh     = {rem_q[62:0], 1'b0};
  assign ge         = rem_sh >= {1'b0, den_q};
  assign quo_nxt    = {quo_q[30:0], ge};

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    addr_d      = addr_q;
    sweep_d     = sweep_q;
    cnt_d       = cnt_q;
    set_d       = set_q;
    quo_d       = quo_q;
    den_d       = den_q;
    rem_d       = rem_q;
    step_d      = step_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    fin         = 1'b0;
    fin_res     = '0;
    job_pop_o   = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = sweep_q;
    mem_wdata_o = '0;
    mem_raddr_o = addr_q;

    case (state_q)
      B_INIT, B_CLR: begin
        mem_we_o = 1'b1;
        sweep_d  = sweep_q + 1'b1;
        if (sweep_last) begin
          sweep_d = '0;
          if (state_q == B_INIT) begin
            state_d = B_IDLE;
          end else begin
            set_d = '0;
            fin   = 1'b1;
          end
        end
      end
      B_IDLE: begin
        mem_raddr_o = job_addr_i;
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          cur_d     = job_i;
          addr_d    = job_addr_i;
          sweep_d   = '0;
          state_d   = (job_i.op == CMD_CLEAR) ? B_CLR : B_EXEC;
        end
      end
      B_EXEC: begin
        case (cur_q.op)
          CMD_ADD: begin
            if (cur_q.hit) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = addr_q;
              mem_wdata_o = sat_inc(mem_rdata_i);
            end
            if (cur_q.closes) begin
              set_d = sat_inc(set_q);
            end
            fin               = 1'b1;
            fin_res.in_range  = cur_q.hit;
            fin_res.set_total = set_d;
          end
          CMD_READ: begin
            cnt_d   = cur_q.hit ? mem_rdata_i : '0;
            den_d   = 63'(bin_width_i) * 63'(set_q);
            state_d = B_DEN;
          end
          default: begin
            fin               = 1'b1;
            fin_res.set_total = set_q;
          end
        endcase
      end
      B_DEN: begin
        fin_res.raw_count = cnt_q;
        fin_res.left_edge = cur_q.left_edge;
        fin_res.set_total = set_q;
        if (!cur_q.hit || den_q == '0) begin
          fin = 1'b1;
        end else if ({31'd0, cnt_q} >= den_q) begin
          fin             = 1'b1;
          fin_res.density = 32'hFFFFFFFF;
        end else begin
          rem_d   = 64'(cnt_q);
          quo_d   = '0;
          step_d  = '0;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
        quo_d  = quo_nxt;
        step_d = step_q + 1'b1;
        if (step_q == 5'd31) begin
          fin               = 1'b1;
          fin_res.raw_count = cnt_q;
          fin_res.density   = quo_nxt;
          fin_res.left_edge = cur_q.left_edge;
          fin_res.set_total = set_q;
        end
      end
      B_OUT: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    if (fin) begin
      res_d   = fin_res;
      state_d = out_free ? B_IDLE : B_OUT;
    end

    if (fin && out_free) begin
      out_d       = fin_res;
      out_valid_d = 1'b1;
    end else if (state_q == B_OUT && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      sweep_q     <= '0;
      set_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      set_q       <= set_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    addr_q <= addr_d;
    cnt_q  <= cnt_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign init_busy_o = (state_q == B_INIT);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fixed_range_histogram_core. A directed table covers
// the edges of the range, every command, the zero reciprocal, density
// saturation and the no-sets case. Random phases under several register
// settings follow, each checked item by item against a bit-exact Q16.16
// histogram tracker kept in the bench, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import fhist_pkg::*;

  localparam int CHANNELS = 8;
  localparam int BINS = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEMS_PER_PHASE = 260;
  localparam int PHASES = 7;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint EDGE_MAX = 64'sd2147483647;
  localparam longint EDGE_MIN = -64'sd2147483648;

  typedef struct {
    bit          is_write;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    in_item_t    it;
    bit          pinned;
    out_item_t   res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;

  logic        pinned_flag = 1'b0;
  out_item_t   pinned_res = '0;

  logic signed [31:0] range_lo = '0;
  logic [30:0]        width_q = 31'd65536;
  logic [31:0]        recip_q = 32'd65536;
  logic [31:0]        hist_mem [CHANNELS*BINS] = '{default: '0};
  logic [31:0]        sets_closed = '0;
  logic [2:0]         last_hit_chan = '0;
  logic [7:0]         last_hit_bin = '0;

  out_item_t pending_results[$];
  row_t      rows[$];
  int        fail_count = 0;
  int        cycle = 0;

  fixed_range_histogram_core #(
    .CHANNELS(CHANNELS),
    .BINS    (BINS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always #5 clk = ~clk;

  function automatic out_item_t histogram_update(in_item_t it);
    out_item_t   r;
    longint      diff;
    longint      e;
    logic [63:0] du;
    logic [63:0] bin;
    logic [63:0] den;
    logic [63:0] quo;
    logic [31:0] c;
    bit          hit;
    int          k;
    r = '0;
    case (it.cmd)
      CMD_ADD: begin
        diff = longint'(it.sample_value) - longint'(range_lo);
        if (diff < 0) begin
          hit = (recip_q == 0);
          bin = '0;
        end else begin
          du = diff;
          bin = (du * {32'b0, recip_q}) >> 32;
          hit = (bin < BINS);
        end
        if (hit && it.channel < CHANNELS) begin
          k = int'(it.channel) * BINS + int'(bin);
          if (hist_mem[k] != '1) hist_mem[k] = hist_mem[k] + 1;
          r.in_range = 1'b1;
          last_hit_chan = it.channel;
          last_hit_bin = bin[7:0];
        end
        if (it.closes_set && sets_closed != '1) sets_closed = sets_closed + 1;
      end
      CMD_READ: begin
        e = longint'(range_lo) + longint'(it.bin_index) * longint'(width_q);
        if (e > EDGE_MAX) e = EDGE_MAX;
        if (e < EDGE_MIN) e = EDGE_MIN;
        r.left_edge = e[31:0];
        if (it.channel < CHANNELS && it.bin_index < BINS) begin
          c = hist_mem[int'(it.channel) * BINS + int'(it.bin_index)];
          r.raw_count = c;
          if (sets_closed != 0 && width_q != 0) begin
            den = {33'b0, width_q} * {32'b0, sets_closed};
            quo = {c, 32'b0} / den;
            r.density = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
          end
        end
      end
      CMD_CLEAR: begin
        foreach (hist_mem[i]) hist_mem[i] = '0;
        sets_closed = '0;
      end
      default: ;
    endcase
    r.set_total = sets_closed;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n) begin
      if (push && !full) begin
        want = histogram_update(in_item);
        pending_results.push_back(pinned_flag ? pinned_res : want);
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result with no item waiting");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("in_range", {31'b0, want.in_range}, {31'b0, out_item.in_range});
          check_field("raw_count", want.raw_count, out_item.raw_count);
          check_field("density", want.density, out_item.density);
          check_field("left_edge", want.left_edge, out_item.left_edge);
          check_field("set_total", want.set_total, out_item.set_total);
        end
      end
    end
  end

  function automatic int draw_gap();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(3, 1);
    if (sel < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Receiver: stall at random, with stretches of steady draining.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if ((cycle / 512) % 5 == 0) begin
        pop <= 1'b1;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = draw_gap();
      end
    end
  end

  function automatic in_item_t item_of(cmd_e c, logic [2:0] ch, logic [31:0] v, logic cs,
                                       logic [7:0] b);
    in_item_t it;
    it.cmd = c;
    it.channel = ch;
    it.sample_value = v;
    it.closes_set = cs;
    it.bin_index = b;
    return it;
  endfunction

  function automatic out_item_t result_of(logic ok, logic [31:0] cnt, logic [31:0] dens,
                                          logic [31:0] lft, logic [31:0] sets);
    out_item_t r;
    r.in_range = ok;
    r.raw_count = cnt;
    r.density = dens;
    r.left_edge = lft;
    r.set_total = sets;
    return r;
  endfunction

  function automatic void row_item(in_item_t it);
    row_t r;
    r = '{default: '0};
    r.it = it;
    rows.push_back(r);
  endfunction

  function automatic void row_pinned(in_item_t it, out_item_t res);
    row_t r;
    r = '{default: '0};
    r.it = it;
    r.pinned = 1'b1;
    r.res = res;
    rows.push_back(r);
  endfunction

  function automatic void row_write(logic [1:0] idx, logic [31:0] v);
    row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    rows.push_back(r);
  endfunction

  function automatic logic signed [31:0] pick_sample();
    longint      v;
    logic [63:0] span;
    int          sel;
    sel = $urandom_range(99);
    if (recip_q == 0) span = 64'h1_0000_0000;
    else span = (64'(BINS) << 32) / {32'b0, recip_q};
    if (sel < 70) begin
      v = longint'(range_lo) + longint'({$urandom, $urandom} % span);
    end else if (sel < 85) begin
      case ($urandom_range(3))
        0: v = longint'(range_lo) - 1;
        1: v = longint'(range_lo);
        2: v = longint'(range_lo) + longint'(span) - 1;
        default: v = longint'(range_lo) + longint'(span);
      endcase
    end else begin
      v = longint'($signed($urandom));
    end
    if (v > EDGE_MAX) v = EDGE_MAX;
    if (v < EDGE_MIN) v = EDGE_MIN;
    return v[31:0];
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       sel;
    it.channel = 3'($urandom_range(7));
    it.sample_value = pick_sample();
    it.closes_set = ($urandom_range(9) == 0);
    it.bin_index = 8'($urandom_range(255));
    sel = $urandom_range(999);
    if (sel < 560) begin
      it.cmd = CMD_ADD;
    end else if (sel < 985) begin
      it.cmd = CMD_READ;
      if ($urandom_range(1)) begin
        it.channel = last_hit_chan;
        it.bin_index = last_hit_bin;
      end
    end else if (sel < 995) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  task automatic send(in_item_t it, bit pin, out_item_t res);
    @(negedge clk);
    push <= 1'b1;
    in_item <= it;
    pinned_flag <= pin;
    pinned_res <= res;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic hold_push(int n);
    repeat (n) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_X_MIN:         range_lo = v;
      REG_BIN_WIDTH:     width_q = v[30:0];
      REG_INV_BIN_WIDTH: recip_q = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] lo;
    logic [31:0] w;
    logic [31:0] rcp;

    row_write(REG_UNUSED, 32'hDEAD_BEEF);
    row_pinned(item_of(CMD_READ, 3'd0, 32'h0, 1'b0, 8'd0), result_of(1'b0, 0, 0, 0, 0));
    row_pinned(item_of(CMD_READ, 3'd7, 32'h0, 1'b0, 8'd255),
               result_of(1'b0, 0, 0, 32'h00FF_0000, 0));
    row_pinned(item_of(CMD_ADD, 3'd0, 32'h0, 1'b0, 8'd0), result_of(1'b1, 0, 0, 0, 0));
    row_pinned(item_of(CMD_ADD, 3'd7, 32'h00FF_FFFF, 1'b1, 8'd0),
               result_of(1'b1, 0, 0, 0, 1));
    row_pinned(item_of(CMD_ADD, 3'd3, 32'h0100_0000, 1'b0, 8'hFF),
               result_of(1'b0, 0, 0, 0, 1));
    row_pinned(item_of(CMD_ADD, 3'd2, 32'h8000_0000, 1'b0, 8'd0),
               result_of(1'b0, 0, 0, 0, 1));
    row_pinned(item_of(CMD_ADD, 3'd5, 32'h7FFF_FFFF, 1'b0, 8'd0),
               result_of(1'b0, 0, 0, 0, 1));
    row_pinned(item_of(CMD_ADD, 3'd0, 32'hFFFF_FFFF, 1'b1, 8'd0),
               result_of(1'b0, 0, 0, 0, 2));
    row_pinned(item_of(CMD_READ, 3'd0, 32'h0, 1'b0, 8'd0),
               result_of(1'b0, 1, 32'd32768, 0, 2));
    row_pinned(item_of(CMD_READ, 3'd7, 32'h0, 1'b0, 8'd255),
               result_of(1'b0, 1, 32'd32768, 32'h00FF_0000, 2));
    row_pinned(item_of(CMD_NONE, 3'd1, 32'h0005_0000, 1'b1, 8'd9),
               result_of(1'b0, 0, 0, 0, 2));
    row_pinned(item_of(CMD_READ, 3'd1, 32'h0, 1'b0, 8'd0), result_of(1'b0, 0, 0, 0, 2));
    row_pinned(item_of(CMD_CLEAR, 3'd0, 32'h0, 1'b0, 8'd0), result_of(1'b0, 0, 0, 0, 0));
    row_pinned(item_of(CMD_READ, 3'd7, 32'h0, 1'b0, 8'd255),
               result_of(1'b0, 0, 0, 32'h00FF_0000, 0));
    row_pinned(item_of(CMD_ADD, 3'd6, 32'h0011_8000, 1'b0, 8'd0),
               result_of(1'b1, 0, 0, 0, 0));
    row_pinned(item_of(CMD_READ, 3'd6, 32'h0, 1'b0, 8'd17),
               result_of(1'b0, 1, 0, 32'h0011_0000, 0));
    row_write(REG_X_MIN, 32'h8000_0000);
    row_write(REG_BIN_WIDTH, 32'h7FFF_FFFF);
    row_write(REG_INV_BIN_WIDTH, 32'h0);
    row_pinned(item_of(CMD_ADD, 3'd4, 32'h7FFF_FFFF, 1'b1, 8'd0),
               result_of(1'b1, 0, 0, 0, 1));
    row_pinned(item_of(CMD_ADD, 3'd4, 32'h8000_0000, 1'b0, 8'd0),
               result_of(1'b1, 0, 0, 0, 1));
    row_item(item_of(CMD_READ, 3'd4, 32'h0, 1'b0, 8'd0));
    row_item(item_of(CMD_READ, 3'd4, 32'h0, 1'b0, 8'd255));
    row_write(REG_X_MIN, 32'h7FFF_FFFF);
    row_write(REG_BIN_WIDTH, 32'h1);
    row_write(REG_INV_BIN_WIDTH, 32'hFFFF_FFFF);
    row_pinned(item_of(CMD_ADD, 3'd4, 32'h7FFF_FFFF, 1'b0, 8'd0),
               result_of(1'b1, 0, 0, 0, 1));
    row_pinned(item_of(CMD_READ, 3'd4, 32'h0, 1'b0, 8'd0),
               result_of(1'b0, 3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1));
    row_item(item_of(CMD_READ, 3'd4, 32'h0, 1'b0, 8'd255));
    row_item(item_of(CMD_ADD, 3'd1, 32'h8000_0000, 1'b1, 8'd0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        wait_drained();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send(rows[i].it, rows[i].pinned, rows[i].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo = 32'h0;         w = 32'd65536;      rcp = 32'd65536;      end
        1: begin lo = -32'sd688128;  w = 32'd16384;      rcp = 32'd262144;     end
        2: begin lo = 32'h8000_0000; w = 32'h7FFF_FFFF;  rcp = 32'd2;          end
        3: begin lo = 32'h7FFF_FFFF; w = 32'd1;          rcp = 32'h0;          end
        4: begin lo = 32'd12345;     w = 32'd3000;       rcp = 32'hFFFF_FFFF;  end
        5: begin
          lo = $urandom;
          w = $urandom_range(32'h0010_0000, 2);
          rcp = 32'(64'h1_0000_0000 / {32'b0, w});
        end
        default: begin
          lo = $urandom;
          w = $urandom_range(32'h7FFF_FFFF, 1);
          rcp = $urandom;
        end
      endcase
      wait_drained();
      write_reg(REG_X_MIN, lo);
      write_reg(REG_BIN_WIDTH, w);
      write_reg(REG_INV_BIN_WIDTH, rcp);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send(random_item(), 1'b0, '0);
        if (i % 80 >= 20) hold_push(draw_gap());
      end
    end

    wait_drained();
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
